### rtl/bbe_pkg.sv
// Shared constants and types for the byte-block entropy block.
// Used by byte_block_entropy and its testbench; depends on nothing else.
`timescale 1ns / 1ps

package bbe_pkg;

   localparam int COUNT_WIDTH = 24;
   localparam int FRAC_BITS   = 16;
   localparam int LOG_FRAC    = 28;
   localparam int LEN_WIDTH   = 24;
   localparam int OUT_WIDTH   = 20;
   localparam int BINS        = 256;
   localparam int BIN_BITS    = 8;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [LEN_WIDTH-1:0]   LEN_MAX   = {LEN_WIDTH{1'b1}};
   localparam logic [63:0]            ENT_MAX   = 64'd8 << FRAC_BITS;

   localparam logic [2:0] REG_MASK_LOW      = 3'd0;
   localparam logic [2:0] REG_MASK_MID_LOW  = 3'd1;
   localparam logic [2:0] REG_MASK_MID_HIGH = 3'd2;
   localparam logic [2:0] REG_MASK_HIGH     = 3'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COUNT,
      ST_LOG_NORM,
      ST_LOG_MUL,
      ST_LOG_UPD,
      ST_BIN_RD,
      ST_BIN_CHK,
      ST_TERM_MUL,
      ST_TERM_ADD,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

### rtl/bbe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the histogram bins of the entropy block.
`timescale 1ns / 1ps

module bbe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/byte_block_entropy.sv
// Top level of the byte-block entropy block: histogram counting and the
// end-of-block entropy pass. Depends on bbe_pkg and bbe_ram.
//
//   channel  direction  handshake             payload
//   req      in         req_tvalid/tready     tdata: data_byte; tlast: last
//   rsp      out        rsp_tvalid/tready     tdata: entropy_q16, block_length
//   csr      in         csr_we                csr_index, csr_wdata
//
// Each byte is a bin read, then a write back through the RAM port; no new byte is taken in between.
// The last byte starts the pass: log2 of the length, then for each bin a read and, if
// not empty, log2 of its count and a term product, both in the shared 32x32 multiplier
// (one squaring per log fraction bit), then a restoring divide by the length.
// Synchronous reset clears control state, masks and bin valid bits.
// A pending result does not block the next block; only the next result waits.
`timescale 1ns / 1ps

module byte_block_entropy
   import bbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [19:0] entropy_q16, [43:20] block_length
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   state_type state_ff, state_in;
   logic [63:0]            mask_ff [4];
   logic [BINS-1:0]        valid_ff, valid_in;
   logic                   valid_rd_ff;
   logic [BIN_BITS-1:0]    byte_ff, byte_in;
   logic                   last_ff, last_in;
   logic [LEN_WIDTH-1:0]   len_ff, len_in;
   logic [BIN_BITS-1:0]    bin_ff, bin_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [31:0]            m_ff, m_in;
   logic [4:0]             e_ff, e_in;
   logic [4:0]             it_ff, it_in;
   logic [32:0]            r_ff, r_in;
   logic [32:0]            loglen_ff, loglen_in;
   logic [32:0]            d_ff, d_in;
   logic                   for_bin_ff, for_bin_in;
   logic [63:0]            prod_ff;
   logic [63:0]            sum_ff, sum_in;
   logic [LEN_WIDTH-1:0]   rem_ff, rem_in;
   logic [5:0]             div_ff, div_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [47:0]            rsp_data_ff, rsp_data_in;

   logic [BIN_BITS-1:0]    rd_addr;
   logic [COUNT_WIDTH-1:0] rd_data;
   logic                   wr_en;
   logic [31:0]            mul_a, mul_b;
   logic [COUNT_WIDTH-1:0] bin_count;
   logic [32:0]            sq;
   logic [64:0]            acc;
   logic [LEN_WIDTH:0]     trial;
   logic [63:0]            quot;
   logic                   skip;

   bbe_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BINS)) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (byte_ff),
      .wr_data (cnt_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rd_addr    = (state_ff == ST_IDLE) ? req_tdata : bin_ff;

   // The one multiplier: mantissa squaring for log2, or count times log difference.
   assign mul_a = (state_ff == ST_TERM_MUL) ? {{(32-COUNT_WIDTH){1'b0}}, cnt_ff} : m_ff;
   assign mul_b = (state_ff == ST_TERM_MUL) ? d_ff[31:0] : m_ff;

   assign bin_count = valid_rd_ff ? rd_data : '0;
   assign skip      = (byte_ff != '0) && mask_ff[byte_ff[7:6]][byte_ff[5:0]];
   assign sq        = prod_ff[63:31];
   assign trial     = {rem_ff, sum_ff[63]};
   assign quot      = sum_ff >> (LOG_FRAC - FRAC_BITS);

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      bin_in       = bin_ff;
      cnt_in       = cnt_ff;
      m_in         = m_ff;
      e_in         = e_ff;
      it_in        = it_ff;
      r_in         = r_ff;
      loglen_in    = loglen_ff;
      d_in         = d_ff;
      for_bin_in   = for_bin_ff;
      sum_in       = sum_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      acc          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               byte_in  = req_tdata;
               last_in  = req_tlast;
               if (len_ff != LEN_MAX) begin
                  len_in = len_ff + 1'b1;
               end
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            cnt_in = bin_count;
            if (!skip && bin_count != COUNT_MAX) begin
               cnt_in            = bin_count + 1'b1;
               wr_en             = 1'b1;
               valid_in[byte_ff] = 1'b1;
            end
            if (last_ff) begin
               m_in       = {{(32-LEN_WIDTH){1'b0}}, len_ff};
               e_in       = 5'd31;
               for_bin_in = 1'b0;
               sum_in     = '0;
               state_in   = ST_LOG_NORM;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOG_NORM: begin
            // Walk the top set bit up to bit 31, one place a cycle.
            if (m_ff[31]) begin
               r_in     = {e_ff, {LOG_FRAC{1'b0}}};
               it_in    = 5'(LOG_FRAC - 1);
               state_in = ST_LOG_MUL;
            end else begin
               m_in = {m_ff[30:0], 1'b0};
               e_in = e_ff - 1'b1;
            end
         end
         ST_LOG_MUL: begin
            state_in = ST_LOG_UPD;
         end
         ST_LOG_UPD: begin
            if (sq[32]) begin
               m_in                 = sq[32:1];
               r_in[{1'b0, it_ff}]  = 1'b1;
            end else begin
               m_in = sq[31:0];
            end
            if (it_ff != '0) begin
               it_in    = it_ff - 1'b1;
               state_in = ST_LOG_MUL;
            end else if (for_bin_ff) begin
               d_in     = (loglen_ff > r_in) ? (loglen_ff - r_in) : '0;
               state_in = ST_TERM_MUL;
            end else begin
               loglen_in  = r_in;
               bin_in     = '0;
               for_bin_in = 1'b1;
               state_in   = ST_BIN_RD;
            end
         end
         ST_BIN_RD: begin
            state_in = ST_BIN_CHK;
         end
         ST_BIN_CHK: begin
            cnt_in = (bin_count > len_ff) ? len_ff : bin_count;
            if (cnt_in == '0) begin
               if (bin_ff == BIN_BITS'(BINS - 1)) begin
                  rem_in   = '0;
                  div_in   = '0;
                  state_in = ST_DIV;
               end else begin
                  bin_in   = bin_ff + 1'b1;
                  state_in = ST_BIN_RD;
               end
            end else begin
               m_in     = {{(32-COUNT_WIDTH){1'b0}}, cnt_in};
               e_in     = 5'd31;
               state_in = ST_LOG_NORM;
            end
         end
         ST_TERM_MUL: begin
            state_in = ST_TERM_ADD;
         end
         ST_TERM_ADD: begin
            // The log difference can reach bit 32; that part adds count << 32.
            acc = {1'b0, sum_ff} + {1'b0, prod_ff}
                + (d_ff[32] ? {1'b0, {(32-COUNT_WIDTH){1'b0}}, cnt_ff, 32'd0} : 65'd0);
            sum_in = acc[64] ? {64{1'b1}} : acc[63:0];
            if (bin_ff == BIN_BITS'(BINS - 1)) begin
               rem_in   = '0;
               div_in   = '0;
               state_in = ST_DIV;
            end else begin
               bin_in   = bin_ff + 1'b1;
               state_in = ST_BIN_RD;
            end
         end
         ST_DIV: begin
            // Restoring divide; the sum register shifts into the quotient.
            if (trial >= {1'b0, len_ff}) begin
               rem_in = LEN_WIDTH'(trial - {1'b0, len_ff});
               sum_in = {sum_ff[62:0], 1'b1};
            end else begin
               rem_in = trial[LEN_WIDTH-1:0];
               sum_in = {sum_ff[62:0], 1'b0};
            end
            div_in = div_ff + 1'b1;
            if (div_ff == 6'd63) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, len_ff,
                               (quot > ENT_MAX) ? ENT_MAX[OUT_WIDTH-1:0]
                                                : quot[OUT_WIDTH-1:0]};
               valid_in     = '0;
               len_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            mask_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_MASK_LOW, REG_MASK_MID_LOW, REG_MASK_MID_HIGH, REG_MASK_HIGH: begin
                  mask_ff[csr_index[1:0]] <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      valid_rd_ff <= valid_ff[rd_addr];
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      bin_ff      <= bin_in;
      cnt_ff      <= cnt_in;
      m_ff        <= m_in;
      e_ff        <= e_in;
      it_ff       <= it_in;
      r_ff        <= r_in;
      loglen_ff   <= loglen_in;
      d_ff        <= d_in;
      for_bin_ff  <= for_bin_in;
      prod_ff     <= mul_a * mul_b;
      sum_ff      <= sum_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_accept_counts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_COUNT))
      else $error("accepted request did not enter the count step");

   a_block_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE) |=> (len_ff == '0 && valid_ff == '0))
      else $error("histogram or length not cleared after a block");

   a_entropy_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({44'd0, rsp_tdata[19:0]} <= ENT_MAX))
      else $error("entropy above eight bits per byte");

endmodule

### tb/byte_block_entropy_tb.sv
// Self-checking bench for byte_block_entropy: feeds byte blocks, predicts each
// block's entropy and length, and checks every response. Depends on bbe_pkg and byte_block_entropy.
`timescale 1ns / 1ps

module byte_block_entropy_tb
   import bbe_pkg::*;
();

   typedef struct packed {
      logic [19:0] entropy_q16;
      logic [23:0] block_length;
   } block_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // Bench copy of the block's state and registers.
   logic [63:0] mask_copy [4];
   logic [63:0] bin_count [256];
   logic [63:0] length_count;
   block_result_type expected_blocks[$];

   int  errors = 0;
   bit  quiet = 1'b0;
   int  long_hold = 0;

   byte_block_entropy uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #200ms;
      $display("byte_block_entropy regression: fail");
      $finish;
   end

   function automatic logic [63:0] log2_q28(input logic [63:0] x);
      logic [63:0] m, r;
      int e;
      x = x & 64'hFFFF_FFFF;
      if (x == 0) return 0;
      e = 31;
      while (e > 0 && x[e] == 1'b0) e--;
      m = x << (31 - e);
      r = 64'(e) << LOG_FRAC;
      for (int i = LOG_FRAC - 1; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= (64'd2 << 31)) begin
            m = m >> 1;
            r[i] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] block_entropy_q16(input logic [63:0] len);
      logic [63:0] loglen, sum, c, lc, d, q, term;
      if (len == 0) return 0;
      loglen = log2_q28(len);
      sum = 0;
      for (int j = 0; j < 256; j++) begin
         c = bin_count[j];
         if (c > len) c = len;
         if (c != 0) begin
            lc = log2_q28(c);
            d = (loglen > lc) ? loglen - lc : 0;
            term = c * d;
            sum = (sum > ~64'd0 - term) ? ~64'd0 : sum + term;
         end
      end
      q = (sum / len) >> (LOG_FRAC - FRAC_BITS);
      if (q > ENT_MAX) q = ENT_MAX;
      if (q > 64'hFFFFF) q = 64'hFFFFF;
      return q;
   endfunction

   task automatic count_byte(input logic [7:0] b, input logic last);
      block_result_type res;
      bit skip;
      skip = (b != 0) && mask_copy[b >> 6][b & 8'd63];
      if (!skip && bin_count[b] < 64'(COUNT_MAX)) bin_count[b]++;
      if (length_count < 64'(LEN_MAX)) length_count++;
      if (last) begin
         res.entropy_q16 = block_entropy_q16(length_count);
         res.block_length = length_count[23:0];
         expected_blocks.push_back(res);
         foreach (bin_count[j]) bin_count[j] = 0;
         length_count = 0;
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = b;
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
      count_byte(b, last);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_block(input int len, input int alphabet);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom_range(0, alphabet - 1)
                      ^ (alphabet == 256 ? 0 : $urandom_range(0, 255) & 8'hF0)),
                   i == len - 1);
   endtask

   task automatic wait_drained();
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx <= REG_MASK_HIGH) mask_copy[idx] = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [63:0] random_mask();
      return {$urandom, $urandom};
   endfunction

   task automatic test_directed();
      send_byte(8'd0, 1'b1);
      send_byte(8'd255, 1'b0);
      send_byte(8'd255, 1'b1);
      send_byte(8'd0, 1'b0);
      send_byte(8'd128, 1'b0);
      send_byte(8'd127, 1'b1);
      // Every value once gives the top of the range, eight bits per byte.
      for (int v = 0; v < 256; v++) send_byte(8'(v), v == 255);
      wait_drained();
   endtask

   task automatic test_masks();
      // All bits set: every value but zero is skipped, including the ignored bit.
      write_reg(REG_MASK_LOW, '1);
      write_reg(REG_MASK_MID_LOW, '1);
      write_reg(REG_MASK_MID_HIGH, '1);
      write_reg(REG_MASK_HIGH, '1);
      send_byte(8'd7, 1'b0);
      send_byte(8'd200, 1'b1);
      send_byte(8'd0, 1'b0);
      send_byte(8'd1, 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(8'd99, 1'b1);
      wait_drained();
      // Writes to unused indexes must not disturb the masks.
      for (int i = REG_MASK_HIGH + 1; i < 8; i++) write_reg(3'(i), '0);
      send_byte(8'd64, 1'b0);
      send_byte(8'd3, 1'b1);
      wait_drained();
      write_reg(REG_MASK_LOW, 64'h5555_5555_5555_5555);
      write_reg(REG_MASK_MID_LOW, 64'hAAAA_AAAA_AAAA_AAAA);
      write_reg(REG_MASK_MID_HIGH, '0);
      write_reg(REG_MASK_HIGH, 64'h8000_0000_0000_0001);
      for (int v = 0; v < 256; v += 3) send_byte(8'(v), v == 255);
      wait_drained();
   endtask

   task automatic test_random(input int n_bytes);
      int sent, len, pick;
      sent = 0;
      while (sent < n_bytes) begin
         if ($urandom_range(0, 9) == 0) begin
            wait_drained();
            for (int r = 0; r < 4; r++)
               write_reg(3'(r), $urandom_range(0, 3) == 0 ? '0 : random_mask());
         end
         pick = $urandom_range(0, 99);
         len = pick < 88 ? $urandom_range(1, 16) : pick < 99 ? $urandom_range(17, 64)
                                                              : $urandom_range(65, 300);
         send_block(len, $urandom_range(0, 1) ? 256 : $urandom_range(1, 8));
         sent += len;
      end
   endtask

   task automatic test_backpressure();
      wait_drained();
      long_hold = 3000;
      repeat (4) send_block(6, 256);
      // Now hold off new requests until everything queued has come back.
      wait_drained();
   endtask

   always @(posedge clock) begin
      block_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_blocks.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            errors++;
         end else begin
            exp_res = expected_blocks.pop_front();
            if (rsp_tdata[19:0] !== exp_res.entropy_q16) begin
               $error("entropy_q16 expected %h actual %h", exp_res.entropy_q16,
                      rsp_tdata[19:0]);
               errors++;
            end
            if (rsp_tdata[43:20] !== exp_res.block_length) begin
               $error("block_length expected %h actual %h", exp_res.block_length,
                      rsp_tdata[43:20]);
               errors++;
            end
         end
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (long_hold > 0) begin
            rsp_tready = 1'b0;
            long_hold--;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   initial begin
      foreach (mask_copy[r]) mask_copy[r] = 0;
      foreach (bin_count[j]) bin_count[j] = 0;
      length_count = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_masks();
      test_random(900);
      test_backpressure();
      quiet = 1'b1;
      test_random(450);
      wait_drained();
      repeat (200) @(negedge clock);
      if (errors == 0 && expected_blocks.size() == 0) begin
         $display("byte_block_entropy regression: pass");
      end else begin
         $display("byte_block_entropy regression: fail");
      end
      $finish;
   end

endmodule
